### rtl/core/eqb_pkg.sv
// Shared types and constants for the exchange queue with byte backpressure.
// Used by the controller, the datapath and the top level; no dependencies of its own.
`default_nettype none

package eqb_pkg;

    // Sizing of the queue and its counters.
    localparam int FIFO_DEPTH    = 64;
    localparam int MAX_PRODUCERS = 64;
    localparam int MAX_WAITERS   = 64;

    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int PROD_W  = $clog2(MAX_PRODUCERS + 1);
    localparam int WAIT_W  = $clog2(MAX_WAITERS + 1);

    // Field widths of the request and the result.
    localparam int ACT_W    = 3;
    localparam int TAG_W    = 32;
    localparam int BYTES_W  = 32;
    localparam int TOTAL_W  = 40;
    localparam int STATUS_W = 2;
    localparam int WAKE_W   = 7;
    localparam int ENTRY_W  = TAG_W + BYTES_W;

    localparam logic [TOTAL_W-1:0] MAX_BYTES_RESET = TOTAL_W'(33554432);

    // Request codes.
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD_PRODUCER = 3'd0,
        ACT_NO_MORE      = 3'd1,
        ACT_DRAIN        = 3'd2,
        ACT_ENQUEUE      = 3'd3,
        ACT_PROD_DONE    = 3'd4,
        ACT_DEQUEUE      = 3'd5,
        ACT_CLOSE        = 3'd6
    } action_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_BLOCKED   = 2'd0,
        ST_WAIT_CONSUMER = 2'd1,
        ST_WAIT_PRODUCER = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/eqb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the queued tag and byte pairs.
`default_nettype none

module eqb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/eqb_ctrl.sv
// Controller state machine: takes one request, then runs it once the result slot is free.
// Depends on eqb_pkg for the state and command types.
`default_nettype none

module eqb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    input  wire eqb_pkg::dp_stat_t stat,
    output eqb_pkg::dp_cmd_t       cmd
);

    eqb_pkg::state_t state_reg;
    eqb_pkg::state_t state_next;
    logic            slot_free;

    // The result register can take a new result when empty or being emptied.
    assign slot_free = !stat.out_valid || out_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eqb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eqb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = eqb_pkg::S_EXEC;
                end
            end
            eqb_pkg::S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = eqb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = eqb_pkg::S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            eqb_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            eqb_pkg::S_EXEC:
            begin
                cmd.execute = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/eqb_datapath.sv
// Datapath: request register, queue memory and pointers, byte total, producer and
// waiter counters, and the result register. Depends on eqb_pkg and eqb_ram.
`default_nettype none

module eqb_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire eqb_pkg::dp_cmd_t                 cmd,
    output eqb_pkg::dp_stat_t                     stat,
    input  wire logic                             cfg_we,
    input  wire logic [eqb_pkg::TOTAL_W-1:0]      cfg_wdata,
    input  wire logic [eqb_pkg::ACT_W-1:0]        action,
    input  wire logic [eqb_pkg::TAG_W-1:0]        payload_tag,
    input  wire logic [eqb_pkg::BYTES_W-1:0]      payload_bytes,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [eqb_pkg::STATUS_W-1:0]          status,
    output logic                                  error,
    output logic                                  data_valid,
    output logic [eqb_pkg::TAG_W-1:0]             data_tag,
    output logic [eqb_pkg::BYTES_W-1:0]           data_bytes,
    output logic                                  drained_out,
    output logic                                  finished,
    output logic [eqb_pkg::WAKE_W-1:0]            wake_consumers,
    output logic [eqb_pkg::WAKE_W-1:0]            wake_producers
);

    localparam int SUM_W = eqb_pkg::PTR_W + 1;

    // Captured request.
    logic [eqb_pkg::ACT_W-1:0]    act_reg;
    logic [eqb_pkg::TAG_W-1:0]    tag_reg;
    logic [eqb_pkg::BYTES_W-1:0]  bytes_reg;

    // Queue state.
    logic [eqb_pkg::TOTAL_W-1:0]  max_bytes_reg;
    logic [eqb_pkg::PTR_W-1:0]    rd_ptr_reg,  rd_ptr_next;
    logic [eqb_pkg::CNT_W-1:0]    count_reg,   count_next;
    logic [eqb_pkg::TOTAL_W-1:0]  total_reg,   total_next;
    logic [eqb_pkg::PROD_W-1:0]   pending_reg, pending_next;
    logic [eqb_pkg::PROD_W-1:0]   drained_reg, drained_next;
    logic                         eop_reg,     eop_next;
    logic                         closed_reg,  closed_next;
    logic [eqb_pkg::WAIT_W-1:0]   cwait_reg,   cwait_next;
    logic [eqb_pkg::WAIT_W-1:0]   pwait_reg,   pwait_next;

    // Result register.
    logic                          out_valid_reg;
    logic [eqb_pkg::STATUS_W-1:0]  status_reg,   status_next;
    logic                          error_reg,    error_next;
    logic                          dvalid_reg,   dvalid_next;
    logic [eqb_pkg::TAG_W-1:0]     dtag_reg,     dtag_next;
    logic [eqb_pkg::BYTES_W-1:0]   dbytes_reg,   dbytes_next;
    logic                          drained_o_reg, drained_o_next;
    logic                          finished_reg, finished_next;
    logic [eqb_pkg::WAKE_W-1:0]    wc_reg,       wc_next;
    logic [eqb_pkg::WAKE_W-1:0]    wp_reg,       wp_next;

    // Memory signals and helpers.
    logic                           ram_we;
    logic [eqb_pkg::PTR_W-1:0]      wr_ptr;
    logic [SUM_W-1:0]               wr_sum;
    logic [eqb_pkg::ENTRY_W-1:0]    ram_rdata;
    logic [eqb_pkg::BYTES_W-1:0]    head_bytes;
    logic [eqb_pkg::TAG_W-1:0]      head_tag;
    logic [eqb_pkg::TOTAL_W:0]      enq_sum;
    logic [eqb_pkg::TOTAL_W-1:0]    enq_total;
    logic [eqb_pkg::TOTAL_W-1:0]    deq_total;
    logic                           fifo_full;
    logic                           fifo_empty;
    logic                           enq_ok;

    // Write slot: read pointer plus fill count, wrapped at the depth.
    assign wr_sum = SUM_W'(rd_ptr_reg) + SUM_W'(count_reg);
    assign wr_ptr = (wr_sum >= SUM_W'(eqb_pkg::FIFO_DEPTH))
                    ? eqb_pkg::PTR_W'(wr_sum - SUM_W'(eqb_pkg::FIFO_DEPTH))
                    : eqb_pkg::PTR_W'(wr_sum);

    assign fifo_full  = (count_reg >= eqb_pkg::CNT_W'(eqb_pkg::FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign enq_ok     = !closed_reg && !fifo_full;
    assign ram_we     = cmd.execute && (act_reg == eqb_pkg::ACT_ENQUEUE) && enq_ok;

    // The head entry is read continuously at the read pointer.
    eqb_ram #(
        .WIDTH (eqb_pkg::ENTRY_W),
        .DEPTH (eqb_pkg::FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr),
        .wdata ({tag_reg, bytes_reg}),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign head_tag   = ram_rdata[eqb_pkg::ENTRY_W-1:eqb_pkg::BYTES_W];
    assign head_bytes = ram_rdata[eqb_pkg::BYTES_W-1:0];

    // Byte total after an enqueue saturates; after a dequeue it floors at zero.
    assign enq_sum   = {1'b0, total_reg} + (eqb_pkg::TOTAL_W + 1)'(bytes_reg);
    assign enq_total = enq_sum[eqb_pkg::TOTAL_W] ? '1 : enq_sum[eqb_pkg::TOTAL_W-1:0];
    assign deq_total = (total_reg >= eqb_pkg::TOTAL_W'(head_bytes))
                       ? total_reg - eqb_pkg::TOTAL_W'(head_bytes) : '0;

    // Request execution: next queue state and the result.
    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        pending_next   = pending_reg;
        drained_next   = drained_reg;
        eop_next       = eop_reg;
        closed_next    = closed_reg;
        cwait_next     = cwait_reg;
        pwait_next     = pwait_reg;
        status_next    = eqb_pkg::ST_NOT_BLOCKED;
        error_next     = 1'b0;
        dvalid_next    = 1'b0;
        dtag_next      = '0;
        dbytes_next    = '0;
        drained_o_next = 1'b0;
        finished_next  = 1'b0;
        wc_next        = '0;
        wp_next        = '0;

        case (act_reg)
            eqb_pkg::ACT_ADD_PRODUCER:
            begin
                if (eop_reg || pending_reg >= eqb_pkg::PROD_W'(eqb_pkg::MAX_PRODUCERS))
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    pending_next = pending_reg + 1'b1;
                end
            end
            eqb_pkg::ACT_NO_MORE:
            begin
                if (eop_reg)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    eop_next = 1'b1;
                    if (pending_reg == '0)
                    begin
                        wc_next    = eqb_pkg::WAKE_W'(cwait_reg);
                        cwait_next = '0;
                    end
                end
            end
            eqb_pkg::ACT_DRAIN:
            begin
                if (closed_reg || drained_reg >= pending_reg)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    drained_next = drained_reg + 1'b1;
                    if (drained_reg + 1'b1 == pending_reg)
                    begin
                        wc_next    = eqb_pkg::WAKE_W'(cwait_reg);
                        cwait_next = '0;
                    end
                end
            end
            eqb_pkg::ACT_ENQUEUE:
            begin
                if (!closed_reg)
                begin
                    if (fifo_full)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        wc_next    = eqb_pkg::WAKE_W'(cwait_reg);
                        cwait_next = '0;
                        total_next = enq_total;
                        if (enq_total >= max_bytes_reg)
                        begin
                            status_next = eqb_pkg::ST_WAIT_CONSUMER;
                            if (pwait_reg >= eqb_pkg::WAIT_W'(eqb_pkg::MAX_WAITERS))
                            begin
                                error_next = 1'b1;
                            end
                            else
                            begin
                                pwait_next = pwait_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            eqb_pkg::ACT_PROD_DONE:
            begin
                if (drained_reg != '0 || pending_reg == '0)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    pending_next = pending_reg - 1'b1;
                    if (eop_reg && pending_reg == eqb_pkg::PROD_W'(1))
                    begin
                        wc_next    = eqb_pkg::WAKE_W'(cwait_reg);
                        cwait_next = '0;
                    end
                end
            end
            eqb_pkg::ACT_DEQUEUE:
            begin
                if (fifo_empty)
                begin
                    if (closed_reg || (eop_reg && pending_reg == '0))
                    begin
                        finished_next = 1'b1;
                    end
                    else if (pending_reg == '0)
                    begin
                        error_next = 1'b1;
                    end
                    else if (drained_reg == pending_reg)
                    begin
                        drained_next   = '0;
                        drained_o_next = 1'b1;
                    end
                    else
                    begin
                        status_next = eqb_pkg::ST_WAIT_PRODUCER;
                        if (cwait_reg >= eqb_pkg::WAIT_W'(eqb_pkg::MAX_WAITERS))
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            cwait_next = cwait_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    dvalid_next = 1'b1;
                    dtag_next   = head_tag;
                    dbytes_next = head_bytes;
                    rd_ptr_next = (rd_ptr_reg == eqb_pkg::PTR_W'(eqb_pkg::FIFO_DEPTH - 1))
                                  ? '0 : rd_ptr_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                    total_next  = deq_total;
                    if (deq_total < max_bytes_reg)
                    begin
                        wp_next    = eqb_pkg::WAKE_W'(pwait_reg);
                        pwait_next = '0;
                    end
                end
            end
            eqb_pkg::ACT_CLOSE:
            begin
                rd_ptr_next = '0;
                count_next  = '0;
                total_next  = '0;
                wp_next     = eqb_pkg::WAKE_W'(pwait_reg);
                wc_next     = eqb_pkg::WAKE_W'(cwait_reg);
                pwait_next  = '0;
                cwait_next  = '0;
                closed_next = 1'b1;
            end
            default:
            begin
                error_next = 1'b0;
            end
        endcase
    end

    // Request capture; payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= action;
            tag_reg   <= payload_tag;
            bytes_reg <= payload_bytes;
        end
    end

    // Threshold register and queue state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= eqb_pkg::MAX_BYTES_RESET;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            pending_reg   <= '0;
            drained_reg   <= '0;
            eop_reg       <= 1'b0;
            closed_reg    <= 1'b0;
            cwait_reg     <= '0;
            pwait_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_bytes_reg <= cfg_wdata;
            end
            if (cmd.execute)
            begin
                rd_ptr_reg  <= rd_ptr_next;
                count_reg   <= count_next;
                total_reg   <= total_next;
                pending_reg <= pending_next;
                drained_reg <= drained_next;
                eop_reg     <= eop_next;
                closed_reg  <= closed_next;
                cwait_reg   <= cwait_next;
                pwait_reg   <= pwait_next;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg    <= status_next;
            error_reg     <= error_next;
            dvalid_reg    <= dvalid_next;
            dtag_reg      <= dtag_next;
            dbytes_reg    <= dbytes_next;
            drained_o_reg <= drained_o_next;
            finished_reg  <= finished_next;
            wc_reg        <= wc_next;
            wp_reg        <= wp_next;
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign error          = error_reg;
    assign data_valid     = dvalid_reg;
    assign data_tag       = dtag_reg;
    assign data_bytes     = dbytes_reg;
    assign drained_out    = drained_o_reg;
    assign finished       = finished_reg;
    assign wake_consumers = wc_reg;
    assign wake_producers = wp_reg;

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eqb_pkg::CNT_W'(eqb_pkg::FIFO_DEPTH))
        else $error("fifo count exceeds depth");

    // Drained producers never outnumber pending producers.
    a_drained_bound: assert property (@(posedge clk) disable iff (!rst_n)
        drained_reg <= pending_reg)
        else $error("drained count exceeds pending count");

    // A closed queue stays empty and holds no bytes.
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> (count_reg == '0 && total_reg == '0))
        else $error("closed queue holds data");

    // A delivered batch is never reported together with an error or finish.
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dvalid_reg) |-> (!error_reg && !finished_reg && !drained_o_reg))
        else $error("batch result carries a failure flag");

endmodule

`default_nettype wire

### rtl/core/exchange_queue_backpressure.sv
// Top level of the exchange queue with byte backpressure.
// Depends on eqb_pkg, eqb_ctrl and eqb_datapath (which holds eqb_ram).
`default_nettype none

// Each request on the input channel is one queue event (add producer, no more
// producers, drain, enqueue, producer done, dequeue, close) and yields exactly one
// result on the output channel. A request is first captured into the request
// register and then executed, with the head batch supplied by the registered read
// of the queue memory. A new request is taken while the previous result still
// waits in the output register; execution stalls only when that register is full
// and not being taken. The queue memory needs no clearing after reset. The byte
// threshold is written through cfg_we and cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
module exchange_queue_backpressure (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [eqb_pkg::TOTAL_W-1:0]      cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [eqb_pkg::ACT_W-1:0]        action,
    input  wire logic [eqb_pkg::TAG_W-1:0]        payload_tag,
    input  wire logic [eqb_pkg::BYTES_W-1:0]      payload_bytes,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [eqb_pkg::STATUS_W-1:0]          status,
    output logic                                  error,
    output logic                                  data_valid,
    output logic [eqb_pkg::TAG_W-1:0]             data_tag,
    output logic [eqb_pkg::BYTES_W-1:0]           data_bytes,
    output logic                                  drained_out,
    output logic                                  finished,
    output logic [eqb_pkg::WAKE_W-1:0]            wake_consumers,
    output logic [eqb_pkg::WAKE_W-1:0]            wake_producers
);

    eqb_pkg::dp_cmd_t  cmd;
    eqb_pkg::dp_stat_t stat;

    // Sequencing of requests.
    eqb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Queue state, memory and result register.
    eqb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .action         (action),
        .payload_tag    (payload_tag),
        .payload_bytes  (payload_bytes),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .error          (error),
        .data_valid     (data_valid),
        .data_tag       (data_tag),
        .data_bytes     (data_bytes),
        .drained_out    (drained_out),
        .finished       (finished),
        .wake_consumers (wake_consumers),
        .wake_producers (wake_producers)
    );

endmodule

`default_nettype wire
